FILE: rtl/be3_pkg.sv
// ----------------------------------------------------------------------------
// be3_pkg
// Shared types and constants for the streaming 3x3 binary erosion block.
// ----------------------------------------------------------------------------
package be3_pkg;

    localparam int CELL_W                 = 10;
    localparam int ROW_W                  = 11;
    localparam int TILE_W                 = 9;
    localparam int CFG_IDX_W              = 1;
    localparam int TILE_SHIFT             = 2;
    localparam int MAX_HEIGHT_TILES       = 256;
    localparam int DEFAULT_MAX_GRID_WIDTH = 1024;
    localparam int WIN_W                  = 9;
    localparam int LINE_W                 = 2;

    localparam logic [TILE_W-1:0] TILES_RESET = 9'd256;
    localparam logic [WIN_W-1:0]  WIN_ONES    = '1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_TILES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_TILES = 1'b1;

    typedef enum logic
    {
        CMD_RAW   = 1'b0,
        CMD_DRAIN = 1'b1
    } be3_cmd_t;

    typedef struct packed
    {
        be3_cmd_t cmd;
        logic     raw_walkable;
    } be3_in_t;

    typedef struct packed
    {
        logic [CELL_W-1:0] cell_col;
        logic [CELL_W-1:0] cell_row;
        logic              eroded_walkable;
        logic              frame_done;
        logic              last_of_run;
    } be3_out_t;

    // work item handed from the input sequencer to the window stage
    typedef struct packed
    {
        logic              is_raw;
        logic              raw;
        logic [CELL_W-1:0] row;
        logic              first_row;
        logic              second_row;
        logic              last_row;
        logic              last_col;
    } be3_item_t;

endpackage

FILE: rtl/binary_erosion_3x3_stream.sv
// an accepted input beat is registered into the window stage, and its result beat then into the output register
// throughput: one beat per cycle while out_stall is low; from row 1 on the last cell of each row holds input
// while it makes two result beats through the single output register
// the line buffer read-modify-write (registered read, write as the item leaves the window stage) sets the stage depth
// reset: counters to zero, both tile counts to 256; line buffers are not cleared
// ----------------------------------------------------------------------------
// binary_erosion_3x3_stream
// Streaming 3x3 erosion of a raster walkability grid with last-row drain.
// ----------------------------------------------------------------------------
module binary_erosion_3x3_stream #(
    parameter int MAX_GRID_WIDTH = be3_pkg::DEFAULT_MAX_GRID_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [be3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [be3_pkg::TILE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  be3_pkg::be3_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output be3_pkg::be3_out_t             out_data
);
    import be3_pkg::*;

    localparam int COL_W = $clog2(MAX_GRID_WIDTH);

    logic              core_ready;
    logic              item_valid;
    be3_item_t         item;
    logic [COL_W-1:0]  item_col;
    logic [LINE_W-1:0] line_rdata;
    logic              drain_rdata;
    logic              line_we;
    logic [COL_W-1:0]  line_waddr;
    logic [LINE_W-1:0] line_wdata;
    logic              drain_we;
    logic [COL_W-1:0]  drain_waddr;
    logic              drain_wdata;

    be3_seq #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .core_ready (core_ready),
        .item_valid (item_valid),
        .item       (item),
        .item_col   (item_col)
    );

    // upper row in bit 0, middle row in bit 1
    be3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .re    (item_valid),
        .raddr (item_col),
        .rdata (line_rdata)
    );

    // eroded values of the final row, filled while that row streams in
    be3_ram #(
        .WIDTH (1),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_drain_ram (
        .clk   (clk),
        .we    (drain_we),
        .waddr (drain_waddr),
        .wdata (drain_wdata),
        .re    (item_valid),
        .raddr (item_col),
        .rdata (drain_rdata)
    );

    be3_core #(
        .MAX_GRID_WIDTH (MAX_GRID_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_col    (item_col),
        .core_ready  (core_ready),
        .line_rdata  (line_rdata),
        .drain_rdata (drain_rdata),
        .line_we     (line_we),
        .line_waddr  (line_waddr),
        .line_wdata  (line_wdata),
        .drain_we    (drain_we),
        .drain_waddr (drain_waddr),
        .drain_wdata (drain_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

FILE: rtl/be3_ram.sv
// ----------------------------------------------------------------------------
// be3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module be3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/be3_seq.sv
// ----------------------------------------------------------------------------
// be3_seq
// Input sequencer: config registers, raster and drain counters, item issue.
// ----------------------------------------------------------------------------
module be3_seq #(
    parameter int MAX_GRID_WIDTH = be3_pkg::DEFAULT_MAX_GRID_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [be3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [be3_pkg::TILE_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  be3_pkg::be3_in_t                  in_data,
    input  logic                              core_ready,
    output logic                              item_valid,
    output be3_pkg::be3_item_t                item,
    output logic [$clog2(MAX_GRID_WIDTH)-1:0] item_col
);
    import be3_pkg::*;

    localparam int COL_W  = $clog2(MAX_GRID_WIDTH);
    localparam int GW_W   = $clog2(MAX_GRID_WIDTH + 1);
    localparam int WT_MAX = MAX_GRID_WIDTH >> TILE_SHIFT;

    logic [TILE_W-1:0] width_tiles_reg, width_tiles_next;
    logic [TILE_W-1:0] height_tiles_reg, height_tiles_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  drain_col_reg, drain_col_next;

    logic [TILE_W-1:0] wt_cl;
    logic [TILE_W-1:0] ht_cl;
    logic [GW_W-1:0]   grid_w;
    logic [GW_W-1:0]   grid_w_m1;
    logic [ROW_W-1:0]  grid_h;
    logic [ROW_W-1:0]  grid_h_m1;
    logic              last_col_raw;
    logic              last_col_drain;
    logic              is_raw;
    logic              active;
    logic              accept;
    logic              cfg_wr;

    // tile counts clamp to the legal range before scaling to cells
    always_comb
    begin
        wt_cl = width_tiles_reg;
        if (width_tiles_reg == '0)
        begin
            wt_cl = TILE_W'(1);
        end
        else if (int'(width_tiles_reg) > WT_MAX)
        begin
            wt_cl = TILE_W'(WT_MAX);
        end

        ht_cl = height_tiles_reg;
        if (height_tiles_reg == '0)
        begin
            ht_cl = TILE_W'(1);
        end
        else if (int'(height_tiles_reg) > MAX_HEIGHT_TILES)
        begin
            ht_cl = TILE_W'(MAX_HEIGHT_TILES);
        end
    end

    assign grid_w    = GW_W'({wt_cl, {TILE_SHIFT{1'b0}}});
    assign grid_w_m1 = grid_w - GW_W'(1);
    assign grid_h    = ROW_W'({ht_cl, {TILE_SHIFT{1'b0}}});
    assign grid_h_m1 = grid_h - ROW_W'(1);

    assign last_col_raw   = (GW_W'(in_col_reg) == grid_w_m1);
    assign last_col_drain = (GW_W'(drain_col_reg) == grid_w_m1);

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign in_stall   = !core_ready;
    assign accept     = in_valid && !in_stall;
    assign is_raw     = (in_data.cmd == CMD_RAW);
    // raw beats past the frame end and early drain beats are dropped here
    assign active     = is_raw ? (in_row_reg < grid_h) : (in_row_reg >= grid_h);
    assign item_valid = accept && active;

    always_comb
    begin
        item.is_raw     = is_raw;
        item.raw        = in_data.raw_walkable;
        item.row        = is_raw ? in_row_reg[CELL_W-1:0] : grid_h_m1[CELL_W-1:0];
        item.first_row  = (in_row_reg == '0);
        item.second_row = (in_row_reg == ROW_W'(1));
        item.last_row   = (in_row_reg == grid_h_m1);
        item.last_col   = is_raw ? last_col_raw : last_col_drain;
        item_col        = is_raw ? in_col_reg : drain_col_reg;
    end

    always_comb
    begin
        width_tiles_next  = width_tiles_reg;
        height_tiles_next = height_tiles_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        drain_col_next    = drain_col_reg;

        if (cfg_wr)
        begin
            if (cfg_index == REG_WIDTH_TILES)
            begin
                width_tiles_next = cfg_data;
            end
            if (cfg_index == REG_HEIGHT_TILES)
            begin
                height_tiles_next = cfg_data;
            end
            in_col_next    = '0;
            in_row_next    = '0;
            drain_col_next = '0;
        end
        else if (item_valid)
        begin
            if (is_raw)
            begin
                if (last_col_raw)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            else if (last_col_drain)
            begin
                // final drain beat starts the next frame
                in_col_next    = '0;
                in_row_next    = '0;
                drain_col_next = '0;
            end
            else
            begin
                drain_col_next = drain_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_tiles_reg  <= TILES_RESET;
            height_tiles_reg <= TILES_RESET;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            drain_col_reg    <= '0;
        end
        else
        begin
            width_tiles_reg  <= width_tiles_next;
            height_tiles_reg <= height_tiles_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            drain_col_reg    <= drain_col_next;
        end
    end

endmodule

FILE: rtl/be3_core.sv
// ----------------------------------------------------------------------------
// be3_core
// Window stage: 3x3 window, line buffer update, result sequencing, output reg.
// ----------------------------------------------------------------------------
module be3_core #(
    parameter int MAX_GRID_WIDTH = be3_pkg::DEFAULT_MAX_GRID_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  be3_pkg::be3_item_t                item,
    input  logic [$clog2(MAX_GRID_WIDTH)-1:0] item_col,
    output logic                              core_ready,
    input  logic [be3_pkg::LINE_W-1:0]        line_rdata,
    input  logic                              drain_rdata,
    output logic                              line_we,
    output logic [$clog2(MAX_GRID_WIDTH)-1:0] line_waddr,
    output logic [be3_pkg::LINE_W-1:0]        line_wdata,
    output logic                              drain_we,
    output logic [$clog2(MAX_GRID_WIDTH)-1:0] drain_waddr,
    output logic                              drain_wdata,
    output logic                              out_valid,
    input  logic                              out_stall,
    output be3_pkg::be3_out_t                 out_data
);
    import be3_pkg::*;

    localparam int COL_W = $clog2(MAX_GRID_WIDTH);

    logic             s1_valid_reg, s1_valid_next;
    be3_item_t        s1_item_reg, s1_item_next;
    logic [COL_W-1:0] s1_col_reg, s1_col_next;
    logic             phase_reg, phase_next;
    logic [WIN_W-1:0] window_reg, window_next;
    logic             dlast_reg, dlast_next;
    logic             out_valid_reg, out_valid_next;
    be3_out_t         out_reg, out_next;

    logic             top_bit;
    logic             mid_bit;
    logic [WIN_W-1:0] win_base;
    logic [WIN_W-1:0] win_new;
    logic             col_nz;
    logic [COL_W-1:0] col_m1;
    logic             raw_emit;
    logic             two;
    logic             has_out;
    logic             out_free;
    logic             s1_done;
    logic             emit;
    logic             raw_done;
    logic             last_row_bit;
    logic             last_col_bit;
    be3_out_t         result;

    // row above row 0 counts as walkable
    assign top_bit  = s1_item_reg.second_row ? 1'b1 : line_rdata[0];
    assign mid_bit  = line_rdata[1];
    assign win_base = (s1_col_reg == '0) ? WIN_ONES : window_reg;
    assign win_new  = {win_base[WIN_W-4:0], s1_item_reg.raw, mid_bit, top_bit};

    assign col_nz   = (s1_col_reg != '0);
    assign col_m1   = s1_col_reg - COL_W'(1);
    assign raw_emit = !s1_item_reg.first_row;
    assign two      = s1_item_reg.is_raw && raw_emit && s1_item_reg.last_col;
    assign has_out  = s1_item_reg.is_raw ? (raw_emit && (col_nz || s1_item_reg.last_col))
                                         : 1'b1;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_done    = s1_valid_reg && (!has_out || (out_free && (!two || phase_reg)));
    assign emit       = s1_valid_reg && has_out && out_free;
    assign core_ready = !s1_valid_reg || s1_done;
    assign raw_done   = s1_done && s1_item_reg.is_raw;

    // last-row results need only the two bottom rows of the window
    assign last_row_bit = &{win_new[8:7], win_new[5:4], win_new[2:1]};
    assign last_col_bit = &{win_new[5:4], win_new[2:1]};

    always_comb
    begin
        result.cell_row    = s1_item_reg.row - CELL_W'(1);
        result.frame_done  = 1'b0;
        if (s1_item_reg.is_raw)
        begin
            if (phase_reg)
            begin
                result.cell_col        = CELL_W'(s1_col_reg);
                result.eroded_walkable = &win_new[5:0];
                result.last_of_run     = 1'b1;
            end
            else
            begin
                result.cell_col        = CELL_W'(col_m1);
                result.eroded_walkable = &win_new;
                result.last_of_run     = !s1_item_reg.last_col;
            end
        end
        else
        begin
            result.cell_col        = CELL_W'(s1_col_reg);
            result.cell_row        = s1_item_reg.row;
            result.eroded_walkable = s1_item_reg.last_col ? dlast_reg : drain_rdata;
            result.frame_done      = s1_item_reg.last_col;
            result.last_of_run     = 1'b1;
        end
    end

    assign line_we     = raw_done;
    assign line_waddr  = s1_col_reg;
    assign line_wdata  = {s1_item_reg.raw, mid_bit};
    assign drain_we    = raw_done && s1_item_reg.last_row && col_nz;
    assign drain_waddr = col_m1;
    assign drain_wdata = last_row_bit;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_item_next   = s1_item_reg;
        s1_col_next    = s1_col_reg;
        phase_next     = phase_reg;
        window_next    = window_reg;
        dlast_next     = dlast_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (core_ready)
        begin
            s1_valid_next = item_valid;
            if (item_valid)
            begin
                s1_item_next = item;
                s1_col_next  = item_col;
            end
        end

        if (s1_done)
        begin
            phase_next = 1'b0;
        end
        else if (emit && two)
        begin
            phase_next = 1'b1;
        end

        if (raw_done)
        begin
            window_next = win_new;
            if (s1_item_reg.last_row && s1_item_reg.last_col)
            begin
                dlast_next = last_col_bit;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = result;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            window_reg    <= WIN_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            window_reg    <= window_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_col_reg  <= s1_col_next;
        dlast_reg   <= dlast_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
